@@ src/dsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_pkg: shared types and constants for the drive slew limiter
// Field widths, register index codes and the register file struct.
// ----------------------------------------------------------------------------
package dsl_pkg;

   localparam int DRIVE_W    = 32;
   localparam int SUM_W      = 64;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CALC_W     = DRIVE_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MAGNITUDE = 1'b1;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] step_size;
      logic [CSR_DATA_W-1:0] min_magnitude;
   } csr_type;

endpackage

@@ src/dsl_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_csr: configuration registers
// Holds step size and minimum magnitude, written through a plain write port.
// ----------------------------------------------------------------------------
module dsl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dsl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dsl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output dsl_pkg::csr_type                 cfg
);

   dsl_pkg::csr_type cfg_ff;
   dsl_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dsl_pkg::CSR_STEP_SIZE:     cfg_in.step_size     = csr_wdata;
            dsl_pkg::CSR_MIN_MAGNITUDE: cfg_in.min_magnitude = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/dsl_next_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_next_level: next drive level
// Floors the target, steps the level toward it with snapping near zero,
// and limits the result to the target. Evaluated in 33 bits.
// ----------------------------------------------------------------------------
module dsl_next_level (
   input  logic signed [dsl_pkg::DRIVE_W-1:0] cur_level,
   input  logic signed [dsl_pkg::DRIVE_W-1:0] target,
   input  dsl_pkg::csr_type                   cfg,
   output logic signed [dsl_pkg::DRIVE_W-1:0] next_level
);

   localparam int W = dsl_pkg::CALC_W;

   always_comb begin
      logic signed [W-1:0] c;
      logic signed [W-1:0] t;
      logic signed [W-1:0] t2;
      logic signed [W-1:0] s;
      logic signed [W-1:0] m;
      logic signed [W-1:0] neg_m;
      logic signed [W-1:0] mag_t;
      logic signed [W-1:0] lvl;

      c     = W'(cur_level);
      t     = W'(target);
      s     = W'($signed({1'b0, cfg.step_size}));
      m     = W'($signed({1'b0, cfg.min_magnitude}));
      neg_m = -m;
      mag_t = (t < 0) ? -t : t;

      // floor: small nonzero targets are pushed out to +/- min magnitude
      t2 = t;
      if (mag_t < m) begin
         if (t < 0) begin
            t2 = neg_m;
         end else if (t > 0) begin
            t2 = m;
         end
      end

      if (s == 0 || t2 == c) begin
         lvl = t2;
      end else if (t2 < c) begin
         lvl = c - s;
         if (t2 <= 0) begin
            if (lvl > 0 && lvl < m) begin
               lvl = '0;
            end else if (lvl < 0 && neg_m < lvl) begin
               lvl = neg_m;
            end
         end
         if (lvl < t2) begin
            lvl = t2;
         end
      end else begin
         lvl = c + s;
         if (t2 >= 0) begin
            if (lvl < 0 && neg_m < lvl) begin
               lvl = '0;
            end else if (lvl > 0 && lvl < m) begin
               lvl = m;
            end
         end
         if (t2 < lvl) begin
            lvl = t2;
         end
      end

      next_level = lvl[dsl_pkg::DRIVE_W-1:0];
   end

endmodule

@@ src/drive_slew_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_slew_limiter: slew-rate limiter for a signed drive level
// Target register, next-level logic, then level and running sum registers.
// ----------------------------------------------------------------------------
// channel  ports                           direction  accepted when
// req      req_valid/ready, req_target     in         req_valid && req_ready
// rsp      rsp_valid/ready, rsp_drive(_sum) out       rsp_valid && rsp_ready
// csr      csr_we, csr_index, csr_wdata    in         csr_we
//
// One item per cycle while the result side is not stalled; an accepted item is held in the
// target reg, then the level update and 64-bit sum add load the level and sum registers.
// A stalled result holds; the target register still takes one more item.
// Synchronous reset clears level, sum, registers and valid flags.
// ----------------------------------------------------------------------------
module drive_slew_limiter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dsl_pkg::DRIVE_W-1:0]  req_target,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dsl_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic signed [dsl_pkg::SUM_W-1:0]    rsp_drive_sum,
   input  logic                                csr_we,
   input  logic [dsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dsl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   dsl_pkg::csr_type cfg;

   logic                               tgt_valid_ff;
   logic                               tgt_valid_in;
   logic signed [dsl_pkg::DRIVE_W-1:0] tgt_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [dsl_pkg::DRIVE_W-1:0] level_ff;
   logic signed [dsl_pkg::DRIVE_W-1:0] level_in;
   logic signed [dsl_pkg::SUM_W-1:0]   sum_ff;
   logic signed [dsl_pkg::SUM_W-1:0]   sum_in;
   logic signed [dsl_pkg::DRIVE_W-1:0] next_level;
   logic                               fire;
   logic                               take;

   dsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dsl_next_level u_next (
      .cur_level  (level_ff),
      .target     (tgt_ff),
      .cfg        (cfg),
      .next_level (next_level)
   );

   assign fire      = tgt_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !tgt_valid_ff || fire;
   assign take      = req_valid && req_ready;

   always_comb begin
      tgt_valid_in = take ? 1'b1 : (fire ? 1'b0 : tgt_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      level_in     = fire ? next_level : level_ff;
      sum_in       = fire ? sum_ff + {{(dsl_pkg::SUM_W-dsl_pkg::DRIVE_W){next_level[
                       dsl_pkg::DRIVE_W-1]}}, next_level} : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tgt_ff <= req_target;
      end
      if (reset) begin
         tgt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         tgt_valid_ff <= tgt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         sum_ff       <= sum_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = level_ff;
   assign rsp_drive_sum = sum_ff;

`ifndef SYNTHESIS
   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("result not loaded after compute");

   a_sum_tracks_level: assert property (@(posedge clock) disable iff (reset)
      fire |=> sum_ff == $past(sum_ff) +
         {{(dsl_pkg::SUM_W-dsl_pkg::DRIVE_W){level_ff[dsl_pkg::DRIVE_W-1]}}, level_ff})
      else $error("running sum does not match new level");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(level_ff) && $stable(sum_ff))
      else $error("state changed without an item");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> tgt_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled while pipeline has room");
`endif

endmodule

@@ test/tb_drive_slew_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drive_slew_limiter: self-checking bench for the drive slew limiter
// Runs a table of directed targets and then random targets under several
// step and floor settings. A behavioral copy of the level and sum update
// predicts each result. Both channels idle at random, and once the
// response side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_drive_slew_limiter;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 150;
   localparam int PHASE_ITEMS    = 210;
   localparam int NUM_PHASES     = 8;
   localparam int NUM_ROWS       = 25;

   typedef struct packed {
      logic [15:0]        step;
      logic [15:0]        mag;
      logic signed [31:0] target;
      logic               typed;
      logic signed [31:0] drive;
   } drive_row_type;

   typedef struct {
      logic signed [dsl_pkg::DRIVE_W-1:0] drive;
      logic signed [dsl_pkg::SUM_W-1:0]   drive_sum;
   } drive_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [dsl_pkg::DRIVE_W-1:0] req_target = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [dsl_pkg::DRIVE_W-1:0] rsp_drive;
   logic signed [dsl_pkg::SUM_W-1:0]   rsp_drive_sum;
   logic                               csr_we = 1'b0;
   logic [dsl_pkg::CSR_IDX_W-1:0]      csr_index = dsl_pkg::CSR_STEP_SIZE;
   logic [dsl_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   dsl_pkg::csr_type                   pred_csr = '0;
   logic signed [dsl_pkg::DRIVE_W-1:0] pred_level = '0;
   logic signed [dsl_pkg::SUM_W-1:0]   pred_sum = '0;
   drive_result_type                   expected_drives[$];
   int                                 errors = 0;
   int                                 stall_count = 0;
   bit                                 quiet = 1'b0;
   bit                                 hold_go = 1'b0;

   drive_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{16'd0,     16'd0,     32'sh7fffffff, 1'b1, 32'sh7fffffff},
      '{16'd0,     16'd0,     32'sh80000000, 1'b1, 32'sh80000000},
      '{16'd0,     16'd0,     32'sd0,        1'b1, 32'sd0},
      '{16'd0,     16'd100,   32'sd5,        1'b1, 32'sd100},
      '{16'd0,     16'd100,   -32'sd1,       1'b1, -32'sd100},
      '{16'd0,     16'd100,   32'sd0,        1'b1, 32'sd0},
      '{16'd0,     16'd100,   -32'sd100,     1'b1, -32'sd100},
      '{16'd65535, 16'd65535, 32'sh7fffffff, 1'b0, 32'sd0},
      '{16'd65535, 16'd65535, 32'sh80000000, 1'b0, 32'sd0},
      '{16'd65535, 16'd65535, 32'sh80000000, 1'b0, 32'sd0},
      '{16'd65535, 16'd65535, 32'sd1,        1'b0, 32'sd0},
      '{16'd0,     16'd0,     32'sd0,        1'b1, 32'sd0},
      '{16'd400,   16'd300,   32'sd500,      1'b0, 32'sd0},
      '{16'd400,   16'd300,   32'sd500,      1'b0, 32'sd0},
      '{16'd400,   16'd300,   -32'sd500,     1'b0, 32'sd0},
      '{16'd400,   16'd300,   -32'sd500,     1'b0, 32'sd0},
      '{16'd400,   16'd300,   -32'sd500,     1'b0, 32'sd0},
      '{16'd400,   16'd300,   32'sd10,       1'b0, 32'sd0},
      '{16'd400,   16'd300,   32'sd10,       1'b0, 32'sd0},
      '{16'd400,   16'd300,   -32'sd2,       1'b0, 32'sd0},
      '{16'd400,   16'd300,   32'sd200,      1'b0, 32'sd0},
      '{16'd0,     16'd300,   -32'sd50,      1'b0, 32'sd0},
      '{16'd0,     16'd300,   32'sd0,        1'b0, 32'sd0},
      '{16'd65535, 16'd0,     32'sh7fffffff, 1'b0, 32'sd0},
      '{16'd65535, 16'd0,     32'sd0,        1'b0, 32'sd0}
   };

   drive_slew_limiter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_target    (req_target),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_drive_sum (rsp_drive_sum),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // level update: floor on the target, bounded step, snap near zero
   function automatic logic signed [dsl_pkg::DRIVE_W-1:0] next_drive(
      input logic signed [dsl_pkg::DRIVE_W-1:0] cur_in,
      input logic signed [dsl_pkg::DRIVE_W-1:0] tgt_in,
      input logic [dsl_pkg::CSR_DATA_W-1:0]     step_in,
      input logic [dsl_pkg::CSR_DATA_W-1:0]     mag_in
   );
      longint cur;
      longint tgt;
      longint stp;
      longint mag;
      longint tgt_abs;
      longint lvl;
      cur = cur_in;
      tgt = tgt_in;
      stp = step_in;
      mag = mag_in;
      tgt_abs = (tgt < 0) ? -tgt : tgt;
      if (tgt_abs < mag) begin
         if (tgt < 0)
            tgt = -mag;
         else if (tgt > 0)
            tgt = mag;
      end
      if (tgt == cur)
         return cur[dsl_pkg::DRIVE_W-1:0];
      if (tgt < cur) begin
         if (stp == 0) begin
            lvl = tgt;
            if (tgt > 0 || lvl >= 0)
               return lvl[dsl_pkg::DRIVE_W-1:0];
            if (-mag < lvl)
               lvl = -mag;
         end else begin
            lvl = cur - stp;
            if (tgt <= 0) begin
               if (lvl > 0 && lvl < mag)
                  return '0;
               if (lvl < 0 && -mag < lvl)
                  lvl = -mag;
            end
         end
         if (lvl < tgt)
            lvl = tgt;
      end else begin
         if (stp == 0) begin
            lvl = tgt;
            if (tgt < 0 || lvl <= 0)
               return lvl[dsl_pkg::DRIVE_W-1:0];
            if (lvl < mag)
               lvl = mag;
         end else begin
            lvl = cur + stp;
            if (tgt >= 0) begin
               if (lvl < 0 && -mag < lvl)
                  return '0;
               if (lvl > 0 && lvl < mag)
                  lvl = mag;
            end
         end
         if (tgt < lvl)
            lvl = tgt;
      end
      return lvl[dsl_pkg::DRIVE_W-1:0];
   endfunction

   function automatic logic signed [dsl_pkg::DRIVE_W-1:0] random_target(
      input logic [dsl_pkg::CSR_DATA_W-1:0] mag
   );
      int span;
      logic signed [dsl_pkg::DRIVE_W-1:0] t;
      span = 2 * int'(mag) + 4;
      case ($urandom_range(0, 5))
         0, 1: t = $urandom;
         2: t = int'($urandom_range(0, 2 * span)) - span;
         3: t = '0;
         4: t = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: t = int'($urandom_range(0, 140000)) - 70000;
      endcase
      return t;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic predict_drive(input logic signed [dsl_pkg::DRIVE_W-1:0] target,
                                input logic typed,
                                input logic signed [dsl_pkg::DRIVE_W-1:0] typed_drive);
      drive_result_type r;
      pred_level = next_drive(pred_level, target, pred_csr.step_size,
                              pred_csr.min_magnitude);
      pred_sum   = pred_sum + {{(dsl_pkg::SUM_W-dsl_pkg::DRIVE_W){
                      pred_level[dsl_pkg::DRIVE_W-1]}}, pred_level};
      r.drive     = typed ? typed_drive : pred_level;
      r.drive_sum = pred_sum;
      expected_drives.push_back(r);
   endtask

   task automatic send_target(input logic signed [dsl_pkg::DRIVE_W-1:0] target,
                              input logic typed,
                              input logic signed [dsl_pkg::DRIVE_W-1:0] typed_drive);
      req_valid  <= 1'b1;
      req_target <= target;
      do @(posedge clock); while (!req_ready);
      predict_drive(target, typed, typed_drive);
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_csr(input logic [dsl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dsl_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == dsl_pkg::CSR_STEP_SIZE)
         pred_csr.step_size = val;
      else
         pred_csr.min_magnitude = val;
   endtask

   // drain the block before touching the registers
   task automatic set_config(input logic [dsl_pkg::CSR_DATA_W-1:0] step,
                             input logic [dsl_pkg::CSR_DATA_W-1:0] mag);
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(dsl_pkg::CSR_STEP_SIZE, step);
      write_csr(dsl_pkg::CSR_MIN_MAGNITUDE, mag);
      csr_we <= 1'b0;
   endtask

   // response side
   initial begin
      drive_result_type exp_r;
      int hold_cnt;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               report_error($sformatf("unexpected item drive=%0d sum=%0d",
                                      rsp_drive, rsp_drive_sum));
            end else begin
               exp_r = expected_drives.pop_front();
               if (rsp_drive !== exp_r.drive)
                  report_error($sformatf("drive got %0d expected %0d",
                                         rsp_drive, exp_r.drive));
               if (rsp_drive_sum !== exp_r.drive_sum)
                  report_error($sformatf("drive_sum got %0d expected %0d",
                                         rsp_drive_sum, exp_r.drive_sum));
            end
         end
         if (hold_go) begin
            hold_go  = 1'b0;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("drive_slew_limiter regression: fail");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [dsl_pkg::CSR_DATA_W-1:0] step;
      logic [dsl_pkg::CSR_DATA_W-1:0] mag;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // registers come up zero; the first rows rely on that
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (directed_rows[i].step != pred_csr.step_size ||
             directed_rows[i].mag != pred_csr.min_magnitude)
            set_config(directed_rows[i].step, directed_rows[i].mag);
         send_target(directed_rows[i].target, directed_rows[i].typed,
                     directed_rows[i].drive);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin step = 16'd0;     mag = 16'd0;     end
            1: begin step = 16'd65535; mag = 16'd65535; end
            2: begin
               step = 16'($urandom_range(1, 2000));
               mag  = 16'($urandom_range(0, 1000));
            end
            3: begin step = 16'd0;     mag = 16'd65535; end
            4: begin step = 16'd65535; mag = 16'd0;     end
            5: begin step = 16'($urandom); mag = 16'($urandom); end
            6: begin
               step = 16'($urandom_range(1, 64));
               mag  = 16'($urandom_range(0, 300));
            end
            default: begin step = 16'd1; mag = 16'd0; end
         endcase
         set_config(step, mag);
         quiet = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 50)
               hold_go = 1'b1;
            send_target(random_target(mag), 1'b0, '0);
         end
         quiet = 1'b0;
      end
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("drive_slew_limiter regression: pass");
      else
         $display("drive_slew_limiter regression: fail");
      $finish;
   end

endmodule
